// ----- rtl/psv_pkg.sv -----
// Shared constants, register codes and reset values of the plucked-string voice.
package psv_pkg;

  // Sample and store geometry. The store depth must be a power of two.
  localparam int SampleBits = 16;
  localparam int StoreDepth = 8192;
  localparam int AddrBits   = $clog2(StoreDepth);

  // Configuration register widths.
  localparam int DelayBits    = 13;
  localparam int BurstBits    = 13;
  localparam int OffsetBits   = 11;
  localparam int GainBits     = 17;
  localparam int CfgDataBits  = 17;
  localparam int CfgIndexBits = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIndexBits-1:0] {
    CfgDelayLength = 2'd0,
    CfgBurstLength = 2'd1,
    CfgPitchOffset = 2'd2,
    CfgGainCoef    = 2'd3
  } cfg_index_e;

  // Register values after reset.
  localparam logic [DelayBits-1:0]         DelayReset  = DelayBits'(100);
  localparam logic [BurstBits-1:0]         BurstReset  = BurstBits'(100);
  localparam logic signed [OffsetBits-1:0] OffsetReset = '0;
  localparam logic [GainBits-1:0]          GainReset   = GainBits'(65535);

endpackage

// ----- rtl/plucked_string_voice.sv -----
// One plucked-string voice: the four-stage pipeline around the string delay store.
//
// One Karplus-Strong voice. Each noise sample transfer yields exactly one voice sample
// transfer through stages one to three and the output register; the voice takes a new
// sample in every cycle unless the output stalls with all stages full. The rate is set
// by the loop from an output sample through the feedback multiplier, the store write and
// the registered store read back to the output sample two items later, which fits in two
// pipeline stages. The string store needs no clearing pass after reset: the write position
// and a wrap flag record which entries have been written, and an entry not yet written
// reads as zero, so samples are taken from the first cycle after reset. The user must write
// configuration through the simple write port only while the voice is idle; the block does
// not enforce this. A reset clears the registers to their defaults and starts a new note.
module plucked_string_voice (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // Excitation input channel.
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic signed [psv_pkg::SampleBits-1:0]        noise_sample_i,
  // Voice output channel.
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic signed [psv_pkg::SampleBits-1:0]        voice_sample_o,
  // Configuration write port.
  input  logic                                         cfg_we_i,
  input  logic [psv_pkg::CfgIndexBits-1:0]             cfg_index_i,
  input  logic [psv_pkg::CfgDataBits-1:0]              cfg_data_i
);

  localparam int SampleBits = psv_pkg::SampleBits;
  localparam int AddrBits   = psv_pkg::AddrBits;
  localparam int GainBits   = psv_pkg::GainBits;
  localparam int TapBits    =
      (AddrBits > psv_pkg::DelayBits ? AddrBits : psv_pkg::DelayBits) + 1;
  // The feedback product: a two-sample sum times the unsigned gain.
  localparam int PairBits   = SampleBits + 1;
  localparam int ProdBits   = PairBits + GainBits + 1;
  // Dividing by two to the gain width halves the sum and removes the Q1.16 scale.
  localparam int FracBits   = GainBits;
  localparam int FbBits     = ProdBits - FracBits;
  localparam int SumBits    = FbBits + 1;
  localparam logic signed [ProdBits-1:0] RoundHalf = ProdBits'(1) <<< (FracBits - 1);
  localparam logic signed [SumBits-1:0]  SumMax    = SumBits'((2 ** (SampleBits - 1)) - 1);
  localparam logic signed [SumBits-1:0]  SumMin    = -SumMax - SumBits'(1);

  // Configuration registers.
  logic [psv_pkg::DelayBits-1:0]         delay_length_q;
  logic [psv_pkg::BurstBits-1:0]         burst_length_q;
  logic signed [psv_pkg::OffsetBits-1:0] pitch_offset_q;
  logic [GainBits-1:0]                   gain_coef_q;

  // Note state at the input.
  logic [AddrBits-1:0]            wp_q;
  logic                           wrapped_q;
  logic [psv_pkg::BurstBits-1:0]  burst_q;

  // Pipeline stages.
  logic                           s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic signed [SampleBits-1:0]   s1_excite_q, s2_excite_q;
  logic [AddrBits-1:0]            s1_wp_q, s2_wp_q, s1_raddr_q, s2_raddr_q;
  logic                           s1_bypass_q, s2_bypass_q, s3_bypass_q;
  logic                           s1_written_q, s2_written_q, s3_written_q;
  logic signed [ProdBits-1:0]     s2_prod_q;
  logic signed [SampleBits-1:0]   s3_sum_q;
  logic [SampleBits-1:0]          ram_rdata;

  // The last three output samples, newest first.
  logic signed [SampleBits-1:0]   hist_q [3];

  // Handshake and stage movement.
  logic out_free, s3_free, s2_free, s1_free;
  logic mv1, mv2, mv3, accept;

  // Combinational values.
  logic                           burst_active;
  logic signed [TapBits-1:0]      tap;
  logic [AddrBits-1:0]            raddr;
  logic signed [SampleBits-1:0]   s3_out;
  logic signed [SampleBits-1:0]   fb_a, fb_b;
  logic signed [PairBits-1:0]     fb_pair;
  logic signed [ProdBits-1:0]     fb_prod;
  logic signed [ProdBits-1:0]     fb_rounded;
  logic signed [FbBits-1:0]       feedback;
  logic signed [SumBits-1:0]      total;
  logic signed [SampleBits-1:0]   sum_sat;

  // A stage advances when the stage after it is empty or advancing too.
  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    s3_free  = !s3_valid_q || out_free;
    s2_free  = !s2_valid_q || s3_free;
    s1_free  = !s1_valid_q || s2_free;
    mv3      = s3_valid_q && out_free;
    mv2      = s2_valid_q && s3_free;
    mv1      = s1_valid_q && s2_free;
    accept   = in_valid_i && s1_free;
  end

  assign in_stall_o     = !s1_free;
  assign out_valid_o    = out_valid_q;
  assign voice_sample_o = hist_q[0];

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q <= psv_pkg::DelayReset;
      burst_length_q <= psv_pkg::BurstReset;
      pitch_offset_q <= psv_pkg::OffsetReset;
      gain_coef_q    <= psv_pkg::GainReset;
    end else if (cfg_we_i) begin
      case (psv_pkg::cfg_index_e'(cfg_index_i))
        psv_pkg::CfgDelayLength: delay_length_q <= cfg_data_i[psv_pkg::DelayBits-1:0];
        psv_pkg::CfgBurstLength: burst_length_q <= cfg_data_i[psv_pkg::BurstBits-1:0];
        psv_pkg::CfgPitchOffset: pitch_offset_q <= cfg_data_i[psv_pkg::OffsetBits-1:0];
        psv_pkg::CfgGainCoef:    gain_coef_q    <= cfg_data_i[GainBits-1:0];
        default: ;
      endcase
    end
  end

  // Read tap, wrapped to the store depth, and whether the noise burst is still running.
  always_comb begin
    burst_active = burst_q < burst_length_q;
    tap = TapBits'(wp_q) - TapBits'(delay_length_q) + TapBits'(pitch_offset_q);
    raddr = tap[AddrBits-1:0];
  end

  // Write position and fill tracking advance per input transfer, burst count in a burst.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      burst_q   <= '0;
    end else if (accept) begin
      wp_q <= wp_q + AddrBits'(1);
      if (&wp_q) begin
        wrapped_q <= 1'b1;
      end
      if (burst_active) begin
        burst_q <= burst_q + psv_pkg::BurstBits'(1);
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Stage one: the gated excitation and the store addresses.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_excite_q  <= burst_active ? noise_sample_i : '0;
      s1_wp_q      <= wp_q;
      s1_raddr_q   <= raddr;
      s1_bypass_q  <= raddr == wp_q;
      s1_written_q <= wrapped_q || (raddr < wp_q);
    end
  end

  // Output sample leaving stage three: the same-cycle write, the store, or zero.
  always_comb begin
    if (s3_bypass_q) begin
      s3_out = s3_sum_q;
    end else if (s3_written_q) begin
      s3_out = signed'(ram_rdata);
    end else begin
      s3_out = '0;
    end
  end

  // Feedback uses the outputs of two and three items back, wherever they are now.
  always_comb begin
    if (s2_valid_q && s3_valid_q) begin
      fb_a = s3_out;
      fb_b = hist_q[0];
    end else if (s2_valid_q || s3_valid_q) begin
      fb_a = hist_q[0];
      fb_b = hist_q[1];
    end else begin
      fb_a = hist_q[1];
      fb_b = hist_q[2];
    end
    fb_pair = PairBits'(fb_a) + PairBits'(fb_b);
    fb_prod = ProdBits'(fb_pair) * ProdBits'(signed'({1'b0, gain_coef_q}));
  end

  // Stage two: the registered feedback product.
  always_ff @(posedge clk_i) begin
    if (mv1) begin
      s2_prod_q    <= fb_prod;
      s2_excite_q  <= s1_excite_q;
      s2_wp_q      <= s1_wp_q;
      s2_raddr_q   <= s1_raddr_q;
      s2_bypass_q  <= s1_bypass_q;
      s2_written_q <= s1_written_q;
    end
  end

  // Round to nearest with ties up, add the excitation and saturate.
  always_comb begin
    fb_rounded = (s2_prod_q + RoundHalf) >>> FracBits;
    feedback   = fb_rounded[FbBits-1:0];
    total      = SumBits'(feedback) + SumBits'(s2_excite_q);
    if (total > SumMax) begin
      sum_sat = SampleBits'(SumMax);
    end else if (total < SumMin) begin
      sum_sat = SampleBits'(SumMin);
    end else begin
      sum_sat = total[SampleBits-1:0];
    end
  end

  // String store: the new sample is written and the tap read in the same transfer.
  psv_ram #(
    .Width (SampleBits),
    .Depth (psv_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mv2),
    .waddr_i (s2_wp_q),
    .wdata_i (sum_sat),
    .re_i    (mv2),
    .raddr_i (s2_raddr_q),
    .rdata_o (ram_rdata)
  );

  // Stage three: the written sum and the tap flags next to the store read data.
  always_ff @(posedge clk_i) begin
    if (mv2) begin
      s3_sum_q     <= sum_sat;
      s3_bypass_q  <= s2_bypass_q;
      s3_written_q <= s2_written_q;
    end
  end

  // Output history; its newest entry is the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
    end else if (mv3) begin
      hist_q[0] <= s3_out;
      hist_q[1] <= hist_q[0];
      hist_q[2] <= hist_q[1];
    end
  end

  // The input side stalls only when every stage holds an item and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // Once the store has wrapped, every entry stays written until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("store wrap flag cleared without reset");

  // Each input transfer moves the write position by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> wp_q == $past(wp_q) + AddrBits'(1))
    else $error("write position did not advance by one");

  // After the burst the excitation entering the pipeline is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !burst_active |=> s1_excite_q == '0)
    else $error("excitation passed after the burst");

  // A tap on an entry never written delivers silence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv3 && !s3_bypass_q && !s3_written_q |=> voice_sample_o == '0)
    else $error("unwritten store entry reached the output");

endmodule

// ----- rtl/psv_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module psv_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read at the address being written returns the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- verif/psv_voice_checker.sv -----
`timescale 1ns / 1ps
// Checker of the plucked-string voice: string prediction and voice sample comparison.
module psv_voice_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic signed [psv_pkg::SampleBits-1:0] noise_sample_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [psv_pkg::SampleBits-1:0] voice_sample_i,
  input  logic                                  cfg_we_i,
  input  logic [psv_pkg::CfgIndexBits-1:0]      cfg_index_i,
  input  logic [psv_pkg::CfgDataBits-1:0]       cfg_data_i,
  output int                                    fail_count_o,
  output int                                    backlog_o
);

  localparam int SampleBits = psv_pkg::SampleBits;
  localparam int StoreDepth = psv_pkg::StoreDepth;
  localparam int AddrBits   = psv_pkg::AddrBits;

  localparam longint VoiceMax = (longint'(1) <<< (SampleBits - 1)) - 1;
  localparam longint VoiceMin = -VoiceMax - 1;

  // Voice settings as last written on the configuration port.
  logic [psv_pkg::DelayBits-1:0]         delay_len;
  logic [psv_pkg::BurstBits-1:0]         burst_len;
  logic signed [psv_pkg::OffsetBits-1:0] bend;
  logic [psv_pkg::GainBits-1:0]          gain;

  // Predicted string state.
  logic signed [SampleBits-1:0]  string_mem [StoreDepth];
  logic [AddrBits-1:0]           wr_pos;
  logic signed [SampleBits-1:0]  avg_hist [2];
  logic                          avg_slot;
  logic signed [SampleBits:0]    avg_sum;
  logic signed [SampleBits-1:0]  last_voice;
  logic [psv_pkg::BurstBits-1:0] burst_cnt;

  // Voice samples predicted but not yet seen on the output channel.
  logic signed [SampleBits-1:0] voice_expected [$];
  logic signed [SampleBits-1:0] want;

  // Advances the string by one tick and returns the voice sample it yields.
  function automatic logic signed [SampleBits-1:0] pluck_step(
    input logic signed [SampleBits-1:0] noise
  );
    longint                       excite;
    longint                       feedback;
    longint                       total;
    logic [AddrBits-1:0]          tap;
    logic signed [SampleBits-1:0] voice;
    excite = 0;
    if (burst_cnt < burst_len) begin
      excite = noise;
      burst_cnt = burst_cnt + 1'b1;
    end
    // Halved two-sample sum times Q1.16 gain, rounded to nearest with ties upward.
    feedback = (longint'(avg_sum) * longint'(gain) + 64'sd65536) >>> 17;
    // The average window slides after the feedback has been taken.
    avg_sum = avg_sum - avg_hist[avg_slot] + last_voice;
    avg_hist[avg_slot] = last_voice;
    avg_slot = ~avg_slot;
    total = excite + feedback;
    if (total > VoiceMax) begin
      total = VoiceMax;
    end else if (total < VoiceMin) begin
      total = VoiceMin;
    end
    string_mem[wr_pos] = SampleBits'(total);
    // The read tap wraps around the store; it may land on the entry just written.
    tap = wr_pos - delay_len + AddrBits'(bend);
    voice = string_mem[tap];
    last_voice = voice;
    wr_pos = wr_pos + 1'b1;
    return voice;
  endfunction

  // Track configuration, predict on each noise transfer, compare on each voice transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len = psv_pkg::DelayReset;
      burst_len = psv_pkg::BurstReset;
      bend = psv_pkg::OffsetReset;
      gain = psv_pkg::GainReset;
      for (int i = 0; i < StoreDepth; i++) begin
        string_mem[i] = '0;
      end
      wr_pos = '0;
      avg_hist[0] = '0;
      avg_hist[1] = '0;
      avg_slot = 1'b0;
      avg_sum = '0;
      last_voice = '0;
      burst_cnt = '0;
      voice_expected.delete();
      fail_count_o = 0;
      backlog_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (psv_pkg::cfg_index_e'(cfg_index_i))
          psv_pkg::CfgDelayLength: delay_len = cfg_data_i[psv_pkg::DelayBits-1:0];
          psv_pkg::CfgBurstLength: burst_len = cfg_data_i[psv_pkg::BurstBits-1:0];
          psv_pkg::CfgPitchOffset: bend = cfg_data_i[psv_pkg::OffsetBits-1:0];
          psv_pkg::CfgGainCoef:    gain = cfg_data_i[psv_pkg::GainBits-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        voice_expected.insert(voice_expected.size(), pluck_step(noise_sample_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (voice_expected.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: voice sample %0d arrived with none outstanding",
                     $time, voice_sample_i);
          end
          fail_count_o++;
        end else begin
          want = voice_expected[0];
          voice_expected.delete(0);
          if (voice_sample_i !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t: voice_sample mismatch: expected %0d, actual %0d",
                       $time, want, voice_sample_i);
            end
            fail_count_o++;
          end
        end
      end
      backlog_o = voice_expected.size();
    end
  end

endmodule

// ----- verif/tb_plucked_string_voice.sv -----
`timescale 1ns / 1ps
// Testbench top of the plucked-string voice: clock, reset, stimulus, stalls and verdict.
module tb_plucked_string_voice;

  localparam int SampleBits    = psv_pkg::SampleBits;
  localparam int CfgDataBits   = psv_pkg::CfgDataBits;
  localparam int DirectedItems = 24;
  localparam int RandomItems   = 1100;
  localparam int LongHold      = 400;
  localparam int QuietLimit    = 4000;
  localparam int DrainCycles   = 8;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [SampleBits-1:0] noise_sample;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SampleBits-1:0] voice_sample;
  logic                         cfg_we;
  psv_pkg::cfg_index_e          cfg_index;
  logic [CfgDataBits-1:0]       cfg_data;

  int fail_count;
  int backlog;
  int sent_count = 0;
  bit tx_steady = 1'b0;
  bit hold_rx = 1'b0;

  plucked_string_voice DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .noise_sample_i (noise_sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .voice_sample_o (voice_sample),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  psv_voice_checker voice_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .noise_sample_i (noise_sample),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .voice_sample_i (voice_sample),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .backlog_o      (backlog)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender gap: none when steady, else mostly none, sometimes short, rarely a long pause.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (tx_steady || pick < 55) begin
      return 0;
    end else if (pick < 88) begin
      return $urandom_range(1, 3);
    end else if (pick < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offers one noise sample after an optional gap and waits for its transfer.
  task automatic offer_noise(input logic signed [SampleBits-1:0] value, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    noise_sample <= value;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Stops offering and waits until every voice sample has come out and the pipe is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes all four voice registers, one per cycle.
  task automatic tune_voice(input int dly, input int burst, input int bend, input int gain);
    cfg_we <= 1'b1;
    cfg_index <= psv_pkg::CfgDelayLength;
    cfg_data <= CfgDataBits'(dly);
    @(posedge clk);
    cfg_index <= psv_pkg::CfgBurstLength;
    cfg_data <= CfgDataBits'(burst);
    @(posedge clk);
    cfg_index <= psv_pkg::CfgPitchOffset;
    cfg_data <= CfgDataBits'(bend);
    @(posedge clk);
    cfg_index <= psv_pkg::CfgGainCoef;
    cfg_data <= CfgDataBits'(gain);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Output side: random stall stretches, quiet stretches, and one long hold on request.
  initial begin
    int pick;
    int span;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          out_stall <= 1'b0;
          span = $urandom_range(40, 120);
        end else if (pick < 9) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 24);
        end else if (pick < 18) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(8, 40);
        end
        // A hold request cuts the current stretch short so the hold starts at once.
        for (int c = 0; c < span && !hold_rx; c++) begin
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_plucked_string_voice: errors");
    $finish;
  end

  // Reset, directed corners, random phases, drain and verdict.
  initial begin
    logic signed [SampleBits-1:0] noise;
    int phase;
    int batch;
    int dly;
    int burst;
    int bend;
    int gain;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    noise_sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= psv_pkg::CfgDelayLength;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: sample extremes under the reset settings, then the corner settings.
    for (int k = 0; k < DirectedItems; k++) begin
      case (k)
        // Tap on the entry written in the same tick, full gain.
        5: begin
          settle();
          tune_voice(2, 8191, 2, 131071);
        end
        // Zero delay length with a bend of 1000.
        10: begin
          settle();
          tune_voice(0, 8191, 1000, 65535);
        end
        // Longest delay and a bend of -1000 wrap around the store; no feedback.
        15: begin
          settle();
          tune_voice(8191, 8191, -1000, 0);
        end
        // Burst length dropped below the ticks already played: excitation stays off.
        20: begin
          settle();
          tune_voice(1, 0, 0, 98304);
        end
        default: ;
      endcase
      case (k % 6)
        0: noise = {1'b0, {(SampleBits - 1){1'b1}}};
        1: noise = {1'b1, {(SampleBits - 1){1'b0}}};
        2: noise = '0;
        3: noise = '1;
        4: noise = {(SampleBits / 2){2'b01}};
        default: noise = {(SampleBits / 2){2'b10}};
      endcase
      offer_noise(noise, pick_gap());
    end

    // Random phases, each under fresh settings written while the voice is idle.
    phase = 0;
    while (sent_count < DirectedItems + RandomItems) begin
      settle();
      case ($urandom_range(0, 9))
        0: dly = 0;
        1: dly = 1;
        2: dly = 8191;
        3, 4, 5: dly = $urandom_range(1, 40);
        6: dly = $urandom_range(41, 1100);
        default: dly = $urandom_range(0, 8191);
      endcase
      case ($urandom_range(0, 7))
        0: bend = -1000;
        1: bend = 1000;
        2, 3: bend = 0;
        4: bend = (dly <= 1000) ? dly : 0;
        default: bend = $urandom_range(0, 2000) - 1000;
      endcase
      case ($urandom_range(0, 5))
        0: burst = 0;
        1: burst = 8191;
        2: burst = $urandom_range(0, sent_count);
        default: burst = sent_count + $urandom_range(0, 200);
      endcase
      case ($urandom_range(0, 5))
        0: gain = 0;
        1: gain = 131071;
        2: gain = 65535;
        3: gain = $urandom_range(58982, 72089);
        default: gain = $urandom_range(0, 131071);
      endcase
      tune_voice(dly, burst, bend, gain);
      tx_steady = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(30, 70);
      // One phase fills the voice against a long output hold.
      if (phase == 2) begin
        hold_rx = 1'b1;
        tx_steady = 1'b1;
        batch = 120;
      end
      repeat (batch) begin
        noise = SampleBits'($urandom);
        if ($urandom_range(0, 7) == 0) begin
          noise = ($urandom_range(0, 1) != 0) ? {1'b0, {(SampleBits - 1){1'b1}}}
                                              : {1'b1, {(SampleBits - 1){1'b0}}};
        end
        offer_noise(noise, pick_gap());
      end
      phase++;
    end

    settle();
    if (fail_count == 0 && backlog == 0) begin
      $display("tb_plucked_string_voice: clean");
    end else begin
      $display("tb_plucked_string_voice: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/psv_pkg.sv
rtl/psv_ram.sv
rtl/plucked_string_voice.sv
verif/psv_voice_checker.sv
verif/tb_plucked_string_voice.sv
